[rtl/core/midi_held_note_tracker_top_assert.svh]
// Assertion macros for the held-note tracker checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef MIDI_HELD_NOTE_TRACKER_TOP_ASSERT_SVH
`define MIDI_HELD_NOTE_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define MHNT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted (active low).
`define MHNT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/mhnt_pkg.sv]
// Shared types and constants for the held-note tracker.
// No dependencies; imported by every module of the block.
package mhnt_pkg;

    // Fixed field widths
    localparam int REQ_W      = 3;
    localparam int CH_W       = 4;
    localparam int NOTE_W     = 7;
    localparam int OUT_CNT_W  = 8;
    localparam int CHAN_CNT_W = 15;
    localparam int TOTAL_W    = 19;

    localparam logic [NOTE_W-1:0]     TOP_NOTE  = 7'd127;
    localparam logic [CHAN_CNT_W-1:0] CHAN_CAP  = 15'd32767;
    localparam logic [TOTAL_W-1:0]    TOTAL_CAP = 19'd524287;

    // Parameter defaults
    localparam int DEF_NUM_CHANNELS = 16;
    localparam int DEF_NUM_NOTES    = 128;
    localparam int DEF_COUNT_BITS   = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_OTHER     = 3'd0,
        REQ_NOTE_ON   = 3'd1,
        REQ_NOTE_OFF  = 3'd2,
        REQ_ALL_OFF   = 3'd3,
        REQ_PEDAL_ON  = 3'd4,
        REQ_PEDAL_OFF = 3'd5,
        REQ_RESET_ALL = 3'd6
    } t_req;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_MODIFY,
        ST_SCAN,
        ST_CHCLR,
        ST_FETCH,
        ST_OUT
    } t_state;

endpackage

[rtl/core/mhnt_note_ram.sv]
// Single-port-write, single-port-read count store with registered read data.
// Depends on mhnt_pkg for the default data width, DEF_COUNT_BITS.
module mhnt_note_ram
    import mhnt_pkg::*;
#(
    parameter int ADDR_W = 11,
    parameter int DATA_W = DEF_COUNT_BITS
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    localparam int DEPTH = 2 ** ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/midi_held_note_tracker_top.sv]
// Top level of the held-note tracker: command port, sequencer, per-channel registers.
// Depends on mhnt_pkg and mhnt_note_ram.
//
//  channel  | direction | handshake       | payload
//  ---------+-----------+-----------------+----------------------------------------------
//  event    | in        | start, busy     | i_req_type, i_channel, i_note
//  result   | out       | o_valid strobe  | o_handled, o_note_held_count,
//           |           |                 | o_channel_held_count, o_all_held_count,
//           |           |                 | o_lowest_held, o_highest_held, o_pedal_held
//
// A word is taken at an edge with start high and busy low; its result word is on the
// outputs for one cycle under o_valid, during which busy is already low again.
// Cycles from accept to next accept: pedal, other or ignored events 3; note on 5;
// all notes off NUM_NOTES + 3; note off NUM_NOTES + 6 (the rescan walks the channel's
// notes through the count memory's single read port); reset all 2^ADDR_W + 3.
// Reset: after i_rst_n the count memory is swept to zero, one entry a cycle,
// 2^ADDR_W cycles (2048 at the defaults) with busy high. The receiver cannot stall.
module midi_held_note_tracker_top
    import mhnt_pkg::*;
#(
    parameter int NUM_CHANNELS = DEF_NUM_CHANNELS,
    parameter int NUM_NOTES    = DEF_NUM_NOTES,
    parameter int COUNT_BITS   = DEF_COUNT_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [CH_W-1:0]       i_channel,
    input  logic [NOTE_W-1:0]     i_note,
    output logic                  o_valid,
    output logic                  o_handled,
    output logic [OUT_CNT_W-1:0]  o_note_held_count,
    output logic [CHAN_CNT_W-1:0] o_channel_held_count,
    output logic [TOTAL_W-1:0]    o_all_held_count,
    output logic [NOTE_W-1:0]     o_lowest_held,
    output logic [NOTE_W-1:0]     o_highest_held,
    output logic                  o_pedal_held
);

    // Address map of the count memory: {channel, note}
    localparam int CH_AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int NOTE_AW = $clog2(NUM_NOTES);
    localparam int ADDR_W  = CH_AW + NOTE_AW;
    localparam int CNT_W   = ADDR_W + 1;

    localparam logic [CH_W:0]       CH_LIM   = (CH_W + 1)'(NUM_CHANNELS);
    localparam logic [NOTE_W:0]     NOTE_LIM = (NOTE_W + 1)'(NUM_NOTES);
    localparam logic [CNT_W-1:0]    NOTE_END = CNT_W'(NUM_NOTES);
    localparam logic [COUNT_BITS-1:0] NOTE_CAP = '1;

    // Control state
    t_state                  r_state, n_state;
    t_req                    r_req, n_req;
    logic [CH_W-1:0]         r_ch, n_ch;
    logic [NOTE_W-1:0]       r_note, n_note;
    logic                    r_ch_ok, n_ch_ok;
    logic                    r_note_ok, n_note_ok;
    logic                    r_handled, n_handled;
    logic                    r_pend, n_pend;
    logic [CNT_W-1:0]        r_cnt, n_cnt;

    // Rescan tracking
    logic                    r_sv, n_sv;
    logic [NOTE_AW-1:0]      r_sn, n_sn;
    logic                    r_any, n_any;
    logic [NOTE_W-1:0]       r_lo, n_lo;
    logic [NOTE_W-1:0]       r_hi, n_hi;

    // Per-channel and total state
    logic [CHAN_CNT_W-1:0]   r_chan [NUM_CHANNELS];
    logic [CHAN_CNT_W-1:0]   n_chan [NUM_CHANNELS];
    logic [NOTE_W-1:0]       r_low  [NUM_CHANNELS];
    logic [NOTE_W-1:0]       n_low  [NUM_CHANNELS];
    logic [NOTE_W-1:0]       r_high [NUM_CHANNELS];
    logic [NOTE_W-1:0]       n_high [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_sus, n_sus;
    logic [TOTAL_W-1:0]      r_total, n_total;

    // Result word
    logic                    r_valid, n_valid;
    logic                    r_out_handled;
    logic [OUT_CNT_W-1:0]    r_out_note_cnt;
    logic [CHAN_CNT_W-1:0]   r_out_chan_cnt;
    logic [TOTAL_W-1:0]      r_out_total;
    logic [NOTE_W-1:0]       r_out_low;
    logic [NOTE_W-1:0]       r_out_high;
    logic                    r_out_pedal;

    // Memory port
    logic                    w_we;
    logic [ADDR_W-1:0]       w_waddr;
    logic [COUNT_BITS-1:0]   w_wdata;
    logic [ADDR_W-1:0]       w_raddr;
    logic [COUNT_BITS-1:0]   w_rdata;

    // Decode helpers
    logic                    in_ch_ok, in_note_ok;
    logic [CH_AW-1:0]        in_idx, cur_idx;
    logic [NOTE_AW-1:0]      cur_nidx;
    logic                    can_inc;

    assign in_ch_ok   = {1'b0, i_channel} < CH_LIM;
    assign in_note_ok = {1'b0, i_note} < NOTE_LIM;
    assign in_idx     = i_channel[CH_AW-1:0];
    assign cur_idx    = r_ch[CH_AW-1:0];
    assign cur_nidx   = r_note[NOTE_AW-1:0];
    assign can_inc    = (w_rdata != NOTE_CAP) && (r_chan[cur_idx] != CHAN_CAP)
                        && (r_total != TOTAL_CAP);

    mhnt_note_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Next state, memory access and register updates
    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_ch      = r_ch;
        n_note    = r_note;
        n_ch_ok   = r_ch_ok;
        n_note_ok = r_note_ok;
        n_handled = r_handled;
        n_pend    = r_pend;
        n_cnt     = r_cnt;
        n_sv      = r_sv;
        n_sn      = r_sn;
        n_any     = r_any;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_chan    = r_chan;
        n_low     = r_low;
        n_high    = r_high;
        n_sus     = r_sus;
        n_total   = r_total;
        n_valid   = 1'b0;
        w_we      = 1'b0;
        w_waddr   = {cur_idx, cur_nidx};
        w_wdata   = '0;
        w_raddr   = {cur_idx, cur_nidx};

        unique case (r_state)
            ST_INIT: begin
                // sweep every entry to zero
                w_we    = 1'b1;
                w_waddr = r_cnt[ADDR_W-1:0];
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt[ADDR_W-1:0] == '1) begin
                    n_state = r_pend ? ST_FETCH : ST_IDLE;
                    n_pend  = 1'b0;
                end
            end

            ST_IDLE: begin
                if (start) begin
                    n_req     = t_req'(i_req_type);
                    n_ch      = i_channel;
                    n_note    = i_note;
                    n_ch_ok   = in_ch_ok;
                    n_note_ok = in_note_ok;
                    n_handled = 1'b0;
                    n_state   = ST_FETCH;
                    if (t_req'(i_req_type) == REQ_RESET_ALL) begin
                        // clear registers now, sweep the memory, then report
                        for (int c = 0; c < NUM_CHANNELS; c++) begin
                            n_chan[c] = '0;
                            n_low[c]  = TOP_NOTE;
                            n_high[c] = '0;
                        end
                        n_sus     = '0;
                        n_total   = '0;
                        n_handled = 1'b1;
                        n_pend    = 1'b1;
                        n_cnt     = '0;
                        n_state   = ST_INIT;
                    end else if (in_ch_ok) begin
                        unique case (t_req'(i_req_type))
                            REQ_NOTE_ON, REQ_NOTE_OFF: begin
                                if (in_note_ok) begin
                                    n_handled = 1'b1;
                                    n_state   = ST_READ;
                                end
                            end
                            REQ_ALL_OFF: begin
                                n_total         = r_total - TOTAL_W'(r_chan[in_idx]);
                                n_chan[in_idx]  = '0;
                                n_low[in_idx]   = TOP_NOTE;
                                n_high[in_idx]  = '0;
                                n_sus[in_idx]   = 1'b0;
                                n_handled       = 1'b1;
                                n_cnt           = '0;
                                n_state         = ST_CHCLR;
                            end
                            REQ_PEDAL_ON: begin
                                n_sus[in_idx] = 1'b1;
                                n_handled     = 1'b1;
                            end
                            REQ_PEDAL_OFF: begin
                                n_sus[in_idx] = 1'b0;
                                n_handled     = 1'b1;
                            end
                            default: begin
                                n_handled = 1'b0;
                            end
                        endcase
                    end
                end
            end

            ST_READ: begin
                // read data for the addressed note lands next cycle
                n_state = ST_MODIFY;
            end

            ST_MODIFY: begin
                if (r_req == REQ_NOTE_ON) begin
                    if (can_inc) begin
                        w_we             = 1'b1;
                        w_wdata          = w_rdata + 1'b1;
                        n_chan[cur_idx]  = r_chan[cur_idx] + 1'b1;
                        n_total          = r_total + 1'b1;
                    end
                    if (r_note < r_low[cur_idx]) begin
                        n_low[cur_idx] = r_note;
                    end
                    if (r_note > r_high[cur_idx]) begin
                        n_high[cur_idx] = r_note;
                    end
                    n_state = ST_FETCH;
                end else begin
                    if (w_rdata != '0) begin
                        w_we             = 1'b1;
                        w_wdata          = w_rdata - 1'b1;
                        n_chan[cur_idx]  = r_chan[cur_idx] - 1'b1;
                        n_total          = r_total - 1'b1;
                    end
                    n_cnt   = '0;
                    n_sv    = 1'b0;
                    n_any   = 1'b0;
                    n_lo    = TOP_NOTE;
                    n_hi    = '0;
                    n_state = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // fold in the entry read last cycle
                if (r_sv && (w_rdata != '0)) begin
                    if (!r_any) begin
                        n_lo = NOTE_W'(r_sn);
                    end
                    n_hi  = NOTE_W'(r_sn);
                    n_any = 1'b1;
                end
                if (r_cnt != NOTE_END) begin
                    w_raddr = {cur_idx, r_cnt[NOTE_AW-1:0]};
                    n_sv    = 1'b1;
                    n_sn    = r_cnt[NOTE_AW-1:0];
                    n_cnt   = r_cnt + 1'b1;
                end else begin
                    n_sv           = 1'b0;
                    n_low[cur_idx] = n_lo;
                    n_high[cur_idx] = n_hi;
                    n_state        = ST_FETCH;
                end
            end

            ST_CHCLR: begin
                w_we    = 1'b1;
                w_waddr = {cur_idx, r_cnt[NOTE_AW-1:0]};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == NOTE_END - 1'b1) begin
                    n_state = ST_FETCH;
                end
            end

            ST_FETCH: begin
                // read the final count of the addressed note
                n_state = ST_OUT;
            end

            ST_OUT: begin
                n_valid = 1'b1;
                n_state = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_pend  <= 1'b0;
            r_cnt   <= '0;
            r_sv    <= 1'b0;
            r_valid <= 1'b0;
            r_sus   <= '0;
            r_total <= '0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_chan[c] <= '0;
                r_low[c]  <= TOP_NOTE;
                r_high[c] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
            r_sv    <= n_sv;
            r_valid <= n_valid;
            r_sus   <= n_sus;
            r_total <= n_total;
            r_chan  <= n_chan;
            r_low   <= n_low;
            r_high  <= n_high;
        end
    end

    // Held event fields and scan accumulators
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_ch      <= n_ch;
        r_note    <= n_note;
        r_ch_ok   <= n_ch_ok;
        r_note_ok <= n_note_ok;
        r_handled <= n_handled;
        r_sn      <= n_sn;
        r_any     <= n_any;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
    end

    // Result word: capture in the last busy cycle, show under the strobe
    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT) begin
            r_out_handled  <= r_handled;
            r_out_note_cnt <= (r_ch_ok && r_note_ok) ? OUT_CNT_W'(w_rdata) : '0;
            r_out_chan_cnt <= r_ch_ok ? r_chan[cur_idx] : '0;
            r_out_total    <= r_total;
            r_out_low      <= r_ch_ok ? r_low[cur_idx] : TOP_NOTE;
            r_out_high     <= r_ch_ok ? r_high[cur_idx] : '0;
            r_out_pedal    <= r_ch_ok ? r_sus[cur_idx] : 1'b0;
        end
    end

    assign busy                 = (r_state != ST_IDLE);
    assign o_valid              = r_valid;
    assign o_handled            = r_out_handled;
    assign o_note_held_count    = r_out_note_cnt;
    assign o_channel_held_count = r_out_chan_cnt;
    assign o_all_held_count     = r_out_total;
    assign o_lowest_held        = r_out_low;
    assign o_highest_held       = r_out_high;
    assign o_pedal_held         = r_out_pedal;

endmodule

[rtl/core/mhnt_chk.sv]
// Port-level checker for the held-note tracker, bound to the top level.
// Depends on mhnt_pkg and midi_held_note_tracker_top_assert.svh.
`include "midi_held_note_tracker_top_assert.svh"

module mhnt_chk
    import mhnt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  o_valid,
    input  logic [OUT_CNT_W-1:0]  o_note_held_count,
    input  logic [CHAN_CNT_W-1:0] o_channel_held_count,
    input  logic [NOTE_W-1:0]     o_lowest_held,
    input  logic [NOTE_W-1:0]     o_highest_held
);

    // strobe lasts one cycle
    `MHNT_ASSERT_NEXT(a_valid_pulse, i_clk, i_rst_n, o_valid, !o_valid)

    // an accepted word makes the block busy
    `MHNT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)

    // empty channel reports the empty bounds
    `MHNT_ASSERT_IMPL(a_empty_bounds, i_clk, i_rst_n,
        o_valid && (o_channel_held_count == '0),
        (o_lowest_held == TOP_NOTE) && (o_highest_held == '0))

    // occupied channel has ordered bounds
    `MHNT_ASSERT_IMPL(a_bounds_order, i_clk, i_rst_n,
        o_valid && (o_channel_held_count != '0), o_lowest_held <= o_highest_held)

    // a held note implies a held channel
    `MHNT_ASSERT_IMPL(a_note_in_chan, i_clk, i_rst_n,
        o_valid && (o_note_held_count != '0), o_channel_held_count != '0)

endmodule

bind midi_held_note_tracker_top mhnt_chk u_mhnt_chk (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .start                (start),
    .busy                 (busy),
    .o_valid              (o_valid),
    .o_note_held_count    (o_note_held_count),
    .o_channel_held_count (o_channel_held_count),
    .o_lowest_held        (o_lowest_held),
    .o_highest_held       (o_highest_held)
);
